// ----- hw/rtl/ahgr_pkg.sv -----
// Shared constants and types for the address handle map with region guard.
`timescale 1ns / 1ps

package ahgr_pkg;

    localparam int KEY_BITS    = 29;
    localparam int SIZE_BITS   = 30;
    localparam int HASH_BITS   = 32;
    localparam int COUNT_BITS  = 32;
    localparam int ACTION_BITS = 3;
    localparam int STATUS_BITS = 4;
    localparam int RSLOT_BITS  = 5;
    localparam int RIDX_BITS   = 6;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    localparam logic [ACTION_BITS-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_LOOKUP  = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DEFINE  = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_WRITE   = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_REVAL   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_HIT         = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS        = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_STALE       = 4'd2;
    localparam logic [STATUS_BITS-1:0] ST_NEW         = 4'd3;
    localparam logic [STATUS_BITS-1:0] ST_UPDATED     = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_FULL        = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_DEFINED     = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_REGFULL     = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_INVALIDATED = 4'd8;
    localparam logic [STATUS_BITS-1:0] ST_COUNTED     = 4'd9;
    localparam logic [STATUS_BITS-1:0] ST_NOREGION    = 4'd10;
    localparam logic [STATUS_BITS-1:0] ST_REVALIDATED = 4'd11;
    localparam logic [STATUS_BITS-1:0] ST_MISMATCH    = 4'd12;
    localparam logic [STATUS_BITS-1:0] ST_BELOW       = 4'd13;

    typedef struct packed {
        logic [KEY_BITS-1:0]   base;
        logic [SIZE_BITS-1:0]  size;
        logic                  valid;
        logic [SIZE_BITS-1:0]  span;
        logic [HASH_BITS-1:0]  hash;
        logic [COUNT_BITS-1:0] write_bytes;
    } region_entry_t;

endpackage

// ----- hw/rtl/ahgr_slot_ram.sv -----
// Single-port-write, registered-read RAM holding the map's slots.
`timescale 1ns / 1ps

module ahgr_slot_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 51
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/address_handle_map_region_guard_unit.sv -----
// Top level: address to handle map with region guard, driven by a small sequencer.
`timescale 1ns / 1ps

// One beat is taken at a time; s_tready stays low until its result beat has been
// taken. Define, unknown actions and an insert or lookup of address zero answer
// straight from idle; any other insert or lookup hashes the address, then reads
// and checks each probed slot (and the region on a lookup hit); a write notice or
// revalidate reads and checks each region examined, plus a bound check when none
// matches. The probe loop through the single-read slot RAM and the region scan
// set the rate. After reset a clearing pass writes every slot empty, one per cycle.
module address_handle_map_region_guard_unit #(
    parameter int TABLE_SLOTS  = 4096,
    parameter int REGION_SLOTS = 32,
    parameter int HANDLE_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // address[31:0], handle, region_index[5:0], length[29:0], span_length[29:0],
    // content_hash[31:0], then zero fill
    input  logic [((130+HANDLE_BITS+7)/8)*8-1:0] s_tdata,
    // action[2:0]
    input  logic [2:0]                s_tuser,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // found_handle, region_slot[4:0], entries_used, then zero fill
    output logic [((HANDLE_BITS+5+$clog2(TABLE_SLOTS+1)+7)/8)*8-1:0] m_tdata,
    // status[3:0]
    output logic [3:0]                m_tuser
);

    localparam int IW   = $clog2(TABLE_SLOTS);
    localparam int EW   = $clog2(TABLE_SLOTS+1);
    localparam int RW   = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW   = $clog2(REGION_SLOTS+1);
    localparam int KB   = ahgr_pkg::KEY_BITS;
    localparam int SW   = KB + HANDLE_BITS + ahgr_pkg::RIDX_BITS;
    localparam int IN_W = 130 + HANDLE_BITS;
    localparam int OUT_W  = HANDLE_BITS + 5 + EW;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PCHK  = 4'd4;
    localparam logic [3:0] S_GRD   = 4'd5;
    localparam logic [3:0] S_GCHK  = 4'd6;
    localparam logic [3:0] S_SRD   = 4'd7;
    localparam logic [3:0] S_SCHK  = 4'd8;

    // Latched input beat.
    logic [2:0]             action_reg;
    logic [KB-1:0]          addr_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [5:0]             ridx_reg;
    logic [29:0]            length_reg;
    logic [31:0]            chash_reg;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] probe_reg, probe_next;
    logic [IW-1:0] pcnt_reg, pcnt_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [EW-1:0] entry_count_reg, entry_count_next;
    logic [CW-1:0] region_count_reg, region_count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [RW-1:0] grd_reg, grd_next;

    logic                   out_valid_reg, out_valid_next;
    logic [3:0]             status_reg, status_next;
    logic [HANDLE_BITS-1:0] found_reg, found_next;
    logic [4:0]             rslot_reg, rslot_next;

    // Slot RAM.
    logic          slot_we;
    logic [IW-1:0] slot_waddr;
    logic [SW-1:0] slot_wdata;
    logic [SW-1:0] slot_rdata;
    logic [KB-1:0] slot_key;
    logic [HANDLE_BITS-1:0] slot_handle;
    logic [5:0]    slot_region;

    // Region store.
    ahgr_pkg::region_entry_t region_mem [REGION_SLOTS];
    ahgr_pkg::region_entry_t region_rd;
    ahgr_pkg::region_entry_t region_wdata;
    logic          region_we;
    logic [RW-1:0] region_waddr;
    logic [RW-1:0] region_raddr;

    logic          accept;
    logic [31:0]   hash_prod;
    logic [30:0]   region_end;
    logic          region_hit;
    logic [32:0]   count_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_TW'({entry_count_reg, rslot_reg, found_reg});

    assign hash_prod = {3'd0, addr_reg} * ahgr_pkg::HASH_MUL;

    assign slot_key    = slot_rdata[KB-1:0];
    assign slot_handle = slot_rdata[KB+HANDLE_BITS-1:KB];
    assign slot_region = slot_rdata[SW-1:KB+HANDLE_BITS];

    assign region_end = {2'd0, region_rd.base} + {1'b0, region_rd.size};
    assign region_hit = ({2'd0, addr_reg} >= {2'd0, region_rd.base})
                     && ({2'd0, addr_reg} < region_end)
                     && !((action_reg == ahgr_pkg::ACT_REVAL) && region_rd.valid);
    assign count_sum  = {1'b0, region_rd.write_bytes} + {3'd0, length_reg};

    assign region_raddr = (state_reg == S_GRD) ? grd_reg : scan_reg[RW-1:0];

    ahgr_slot_ram #(
        .DEPTH(TABLE_SLOTS),
        .WIDTH(SW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (probe_reg),
        .rdata (slot_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (region_we)
        begin
            region_mem[region_waddr] <= region_wdata;
        end
        region_rd <= region_mem[region_raddr];
    end

    always_comb
    begin
        state_next        = state_reg;
        probe_next        = probe_reg;
        pcnt_next         = pcnt_reg;
        clr_next          = clr_reg;
        entry_count_next  = entry_count_reg;
        region_count_next = region_count_reg;
        scan_next         = scan_reg;
        grd_next          = grd_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        found_next        = found_reg;
        rslot_next        = rslot_reg;
        slot_we           = 1'b0;
        slot_waddr        = probe_reg;
        slot_wdata        = {ridx_reg, handle_reg, addr_reg};
        region_we         = 1'b0;
        region_waddr      = scan_reg[RW-1:0];
        region_wdata      = region_rd;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == {IW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ahgr_pkg::ST_MISS;
                    found_next  = '0;
                    rslot_next  = '0;
                    scan_next   = '0;
                    unique case (s_tuser) inside
                        ahgr_pkg::ACT_INSERT, ahgr_pkg::ACT_LOOKUP:
                        begin
                            if (s_tdata[KB-1:0] == '0)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_HASH;
                            end
                        end
                        ahgr_pkg::ACT_DEFINE:
                        begin
                            out_valid_next = 1'b1;
                            if (32'(region_count_reg) >= REGION_SLOTS)
                            begin
                                status_next = ahgr_pkg::ST_REGFULL;
                            end
                            else
                            begin
                                region_we                = 1'b1;
                                region_waddr             = region_count_reg[RW-1:0];
                                region_wdata.base        = s_tdata[KB-1:0];
                                region_wdata.size        = s_tdata[HANDLE_BITS+67:HANDLE_BITS+38];
                                region_wdata.valid       = 1'b1;
                                region_wdata.span        = s_tdata[HANDLE_BITS+97:HANDLE_BITS+68];
                                region_wdata.hash        = s_tdata[IN_W-1:HANDLE_BITS+98];
                                region_wdata.write_bytes = '0;
                                region_count_next        = region_count_reg + 1'b1;
                                status_next              = ahgr_pkg::ST_DEFINED;
                                rslot_next               = 5'(region_count_reg);
                            end
                        end
                        ahgr_pkg::ACT_WRITE, ahgr_pkg::ACT_REVAL:
                        begin
                            state_next = S_SRD;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                probe_next = hash_prod[IW-1:0];
                pcnt_next  = '0;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (action_reg == ahgr_pkg::ACT_INSERT)
                begin
                    if (slot_key == '0 || slot_key == addr_reg)
                    begin
                        slot_we        = 1'b1;
                        rslot_next     = ridx_reg[5] ? 5'd0 : ridx_reg[4:0];
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                        if (slot_key == '0)
                        begin
                            entry_count_next = entry_count_reg + 1'b1;
                            status_next      = ahgr_pkg::ST_NEW;
                        end
                        else
                        begin
                            status_next = ahgr_pkg::ST_UPDATED;
                        end
                    end
                    else if (pcnt_reg == {IW{1'b1}})
                    begin
                        status_next    = ahgr_pkg::ST_FULL;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                        pcnt_next  = pcnt_reg + 1'b1;
                        state_next = S_PRD;
                    end
                end
                else
                begin
                    if (slot_key == '0)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (slot_key == addr_reg)
                    begin
                        rslot_next = slot_region[5] ? 5'd0 : slot_region[4:0];
                        found_next = slot_handle;
                        // An entry whose region is negative or not yet defined is unguarded.
                        if (!slot_region[5] && (32'(slot_region) < 32'(region_count_reg)))
                        begin
                            grd_next   = slot_region[RW-1:0];
                            state_next = S_GRD;
                        end
                        else
                        begin
                            status_next    = ahgr_pkg::ST_HIT;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else if (pcnt_reg == {IW{1'b1}})
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                        pcnt_next  = pcnt_reg + 1'b1;
                        state_next = S_PRD;
                    end
                end
            end
            S_GRD:
            begin
                state_next = S_GCHK;
            end
            S_GCHK:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (region_rd.valid)
                begin
                    status_next = ahgr_pkg::ST_HIT;
                end
                else
                begin
                    status_next = ahgr_pkg::ST_STALE;
                    found_next  = '0;
                end
            end
            S_SRD:
            begin
                if (scan_reg >= region_count_reg)
                begin
                    status_next    = ahgr_pkg::ST_NOREGION;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (region_hit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    rslot_next     = 5'(scan_reg);
                    if (action_reg == ahgr_pkg::ACT_WRITE)
                    begin
                        region_we = 1'b1;
                        if (region_rd.valid)
                        begin
                            region_wdata.valid       = 1'b0;
                            region_wdata.write_bytes = '0;
                            status_next              = ahgr_pkg::ST_INVALIDATED;
                        end
                        else
                        begin
                            region_wdata.write_bytes = count_sum[32] ? '1 : count_sum[31:0];
                            status_next              = ahgr_pkg::ST_COUNTED;
                        end
                    end
                    else if (region_rd.write_bytes < {3'd0, region_rd.span[29:1]})
                    begin
                        status_next = ahgr_pkg::ST_BELOW;
                    end
                    else
                    begin
                        region_we                = 1'b1;
                        region_wdata.write_bytes = '0;
                        if (chash_reg == region_rd.hash)
                        begin
                            region_wdata.valid = 1'b1;
                            status_next        = ahgr_pkg::ST_REVALIDATED;
                        end
                        else
                        begin
                            status_next = ahgr_pkg::ST_MISMATCH;
                        end
                    end
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            entry_count_reg  <= '0;
            region_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            entry_count_reg  <= entry_count_next;
            region_count_reg <= region_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg  <= probe_next;
        pcnt_reg   <= pcnt_next;
        scan_reg   <= scan_next;
        grd_reg    <= grd_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rslot_reg  <= rslot_next;
        if (accept)
        begin
            action_reg <= s_tuser;
            addr_reg   <= s_tdata[KB-1:0];
            handle_reg <= s_tdata[HANDLE_BITS+31:32];
            ridx_reg   <= s_tdata[HANDLE_BITS+37:HANDLE_BITS+32];
            length_reg <= s_tdata[HANDLE_BITS+67:HANDLE_BITS+38];
            chash_reg  <= s_tdata[IN_W-1:HANDLE_BITS+98];
        end
    end

endmodule

// ----- hw/rtl/ahgr_checker.sv -----
// Port-level checks on the address handle map, bound to the top level.
`timescale 1ns / 1ps

module ahgr_checker #(
    parameter int TABLE_SLOTS = 4096,
    parameter int HANDLE_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((HANDLE_BITS+5+$clog2(TABLE_SLOTS+1)+7)/8)*8-1:0] m_tdata,
    input logic [3:0] m_tuser
);

    // A new beat is never taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // Each accepted beat keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block ready right after accepting a beat");

    // Only a hit carries a handle.
    a_handle_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ahgr_pkg::ST_HIT)) |-> (m_tdata[HANDLE_BITS-1:0] == '0))
        else $error("handle reported without a hit");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("result dropped while stalled");

endmodule

bind address_handle_map_region_guard_unit ahgr_checker #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
) u_ahgr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
